// ----- rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the LRU key-value cache: payload structs, controller command and
// status structs, field widths and register map constants. No dependencies.
package lkvc_pkg;

   localparam int KEY_WIDTH      = 10;
   localparam int VALUE_WIDTH    = 32;
   localparam int CAP_WIDTH      = 11;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 11'd1024;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic                          opcode;
      logic [KEY_WIDTH-1:0]          key;
      logic signed [VALUE_WIDTH-1:0] put_value;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [VALUE_WIDTH-1:0] read_value;
      logic                          evicted;
      logic [KEY_WIDTH-1:0]          evicted_key;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic look;
      logic store_value;
      logic unlink;
      logic insert;
      logic link;
      logic tail;
      logic ev_read;
      logic evict;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_range;
      logic hit;
      logic is_put;
      logic key_is_tail;
      logic evict_due;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// Top level of the LRU key-value cache: configuration registers, controller
// and datapath. Depends on lkvc_pkg, lkvc_ctrl and lkvc_dpath.
//
// A get or put runs accept, lookup and result steps when it leaves the recency
// list alone (get miss, hit on the most recent key, out-of-range key), adds
// link and tail steps when it relinks or inserts a key, and victim-read and
// evict steps when a put also evicts the least recent key. Each step makes at
// most one access to each single-ported link memory, whose reads are
// registered. The last step waits for as long as the result register holds an
// earlier result that the receiver stalls; the new result loads in the same
// cycle as that result leaves. After reset, a clearing pass writes the whole
// valid table with req_stall high; the capacity register stays writable then.
module lru_key_value_cache #(
   parameter int NUM_KEYS = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lkvc_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lkvc_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   logic [lkvc_pkg::CAP_WIDTH-1:0] capacity_ff, capacity_in;
   logic                           csr_write;
   logic                           csr_index;
   lkvc_pkg::cmd_type              cmd;
   lkvc_pkg::status_type           status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[lkvc_pkg::CSR_ADDR_WIDTH-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      csr_prdata  = '0;
      unique case (csr_index)
         lkvc_pkg::REG_CAPACITY: begin
            csr_prdata = lkvc_pkg::CSR_DATA_WIDTH'(capacity_ff);
            if (csr_write) begin
               capacity_in = csr_pwdata[lkvc_pkg::CAP_WIDTH-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_dpath #(
      .NUM_KEYS (NUM_KEYS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/lkvc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the LRU key-value cache. It sequences the
// lookup, relinking and eviction steps. Depends on lkvc_pkg.
module lkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lkvc_pkg::status_type status,
   output lkvc_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOK   = 3'd2;
   localparam logic [2:0] ST_LINK   = 3'd3;
   localparam logic [2:0] ST_TAIL   = 3'd4;
   localparam logic [2:0] ST_EVREAD = 3'd5;
   localparam logic [2:0] ST_EVICT  = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_DONE;
            if (status.in_range) begin
               if (status.hit) begin
                  cmd.store_value = status.is_put;
                  if (!status.key_is_tail) begin
                     cmd.unlink = 1'b1;
                     state_in   = ST_LINK;
                  end
               end else if (status.is_put) begin
                  cmd.store_value = 1'b1;
                  cmd.insert      = 1'b1;
                  state_in        = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            cmd.tail = 1'b1;
            state_in = status.evict_due ? ST_EVREAD : ST_DONE;
         end
         ST_EVREAD: begin
            cmd.ev_read = 1'b1;
            state_in    = ST_EVICT;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> $past(cmd.ev_read))
      else $error("Eviction without a preceding victim link read.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.look)
      else $error("Lookup does not follow an accepted transfer.");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.accept, cmd.look, cmd.link, cmd.tail,
                cmd.ev_read, cmd.evict, cmd.load_rsp}))
      else $error("More than one sequencing step issued at once.");

endmodule

// ----- rtl/lkvc_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the LRU key-value cache: value, valid and link memories, list
// head and tail, entry count and result register. Depends on lkvc_pkg.
module lkvc_dpath #(
   parameter int NUM_KEYS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lkvc_pkg::cmd_type                    cmd,
   output lkvc_pkg::status_type                 status,
   input  lkvc_pkg::req_type                    req_data,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]       capacity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lkvc_pkg::rsp_type                    rsp_data
);

   localparam int TableDepth = (NUM_KEYS < (1 << lkvc_pkg::KEY_WIDTH)) ?
                               NUM_KEYS : (1 << lkvc_pkg::KEY_WIDTH);
   localparam int IndexWidth = $clog2(TableDepth);
   localparam int LinkWidth  = $clog2(TableDepth + 1);
   localparam logic [LinkWidth-1:0] Sentinel = LinkWidth'(TableDepth);

   typedef logic [LinkWidth-1:0]  link_type;
   typedef logic [IndexWidth-1:0] index_type;

   logic                               valid_mem [TableDepth];
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   value_mem [TableDepth];
   link_type                           prev_mem  [TableDepth];
   link_type                           next_mem  [TableDepth];

   logic                               valid_rd_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   value_rd_ff;
   link_type                           prev_rd_ff;
   link_type                           next_rd_ff;

   logic                               op_ff;
   logic [lkvc_pkg::KEY_WIDTH-1:0]     key_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   put_value_ff;
   link_type                           head_ff, head_in;
   link_type                           tail_ff, tail_in;
   link_type                           count_ff, count_in;
   index_type                          clear_addr_ff, clear_addr_in;
   logic                               hit_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   read_value_ff;
   logic                               evicted_ff;
   logic [lkvc_pkg::KEY_WIDTH-1:0]     evicted_key_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_type                  rsp_data_ff;

   index_type key_idx, head_idx, tail_idx, prev_idx, next_idx, read_addr;
   link_type  key_link;
   logic      in_range, hit_now, read_en;

   logic      valid_we, valid_wdata;
   index_type valid_waddr;
   logic      prev_we, next_we;
   index_type prev_waddr, next_waddr;
   link_type  prev_wdata, next_wdata;

   assign key_idx  = key_ff[IndexWidth-1:0];
   assign key_link = LinkWidth'(key_idx);
   assign head_idx = head_ff[IndexWidth-1:0];
   assign tail_idx = tail_ff[IndexWidth-1:0];
   assign prev_idx = prev_rd_ff[IndexWidth-1:0];
   assign next_idx = next_rd_ff[IndexWidth-1:0];
   assign in_range = ({1'b0, key_ff} < (lkvc_pkg::KEY_WIDTH + 1)'(TableDepth));
   assign hit_now  = in_range && valid_rd_ff;

   assign read_en   = cmd.accept || cmd.ev_read;
   assign read_addr = cmd.ev_read ? head_idx : req_data.key[IndexWidth-1:0];

   always_comb begin
      valid_we    = 1'b0;
      valid_waddr = key_idx;
      valid_wdata = 1'b0;
      if (cmd.clear) begin
         valid_we    = 1'b1;
         valid_waddr = clear_addr_ff;
      end else if (cmd.insert) begin
         valid_we    = 1'b1;
         valid_wdata = 1'b1;
      end else if (cmd.evict) begin
         valid_we    = 1'b1;
         valid_waddr = head_idx;
      end
   end

   always_comb begin
      prev_we    = 1'b0;
      prev_waddr = key_idx;
      prev_wdata = tail_ff;
      if (cmd.unlink) begin
         prev_we    = 1'b1;
         prev_waddr = next_idx;
         prev_wdata = prev_rd_ff;
      end else if (cmd.link) begin
         prev_we    = 1'b1;
      end else if (cmd.evict) begin
         prev_we    = (next_rd_ff != Sentinel);
         prev_waddr = next_idx;
         prev_wdata = Sentinel;
      end
   end

   always_comb begin
      next_we    = 1'b0;
      next_waddr = key_idx;
      next_wdata = Sentinel;
      if (cmd.unlink) begin
         next_we    = (prev_rd_ff != Sentinel);
         next_waddr = prev_idx;
         next_wdata = next_rd_ff;
      end else if (cmd.link) begin
         next_we    = (tail_ff != Sentinel);
         next_waddr = tail_idx;
         next_wdata = key_link;
      end else if (cmd.tail) begin
         next_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_waddr] <= valid_wdata;
      end
      if (cmd.store_value) begin
         value_mem[key_idx] <= put_value_ff;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (read_en) begin
         valid_rd_ff <= valid_mem[read_addr];
         value_rd_ff <= value_mem[read_addr];
         prev_rd_ff  <= prev_mem[read_addr];
         next_rd_ff  <= next_mem[read_addr];
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.unlink && (prev_rd_ff == Sentinel)) begin
         head_in = next_rd_ff;
      end else if (cmd.link && (tail_ff == Sentinel)) begin
         head_in = key_link;
      end else if (cmd.evict) begin
         head_in = next_rd_ff;
      end
   end

   always_comb begin
      tail_in = tail_ff;
      if (cmd.tail) begin
         tail_in = key_link;
      end else if (cmd.evict && (next_rd_ff == Sentinel)) begin
         tail_in = Sentinel;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.evict) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign clear_addr_in = cmd.clear ? clear_addr_ff + 1'b1 : clear_addr_ff;
   assign rsp_valid_in  = cmd.load_rsp ? 1'b1 :
                          (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= Sentinel;
         tail_ff       <= Sentinel;
         count_ff      <= '0;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= req_data.opcode;
         key_ff         <= req_data.key;
         put_value_ff   <= req_data.put_value;
         evicted_ff     <= 1'b0;
         evicted_key_ff <= '0;
      end
      if (cmd.look) begin
         hit_ff        <= hit_now;
         read_value_ff <= (hit_now && (op_ff == lkvc_pkg::OP_GET)) ? value_rd_ff : '0;
      end
      if (cmd.evict) begin
         evicted_ff     <= 1'b1;
         evicted_key_ff <= lkvc_pkg::KEY_WIDTH'(head_ff);
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.hit         <= hit_ff;
         rsp_data_ff.read_value  <= read_value_ff;
         rsp_data_ff.evicted     <= evicted_ff;
         rsp_data_ff.evicted_key <= evicted_key_ff;
      end
   end

   always_comb begin
      status.clear_last  = (clear_addr_ff == IndexWidth'(TableDepth - 1));
      status.in_range    = in_range;
      status.hit         = hit_now;
      status.is_put      = (op_ff == lkvc_pkg::OP_PUT);
      status.key_is_tail = (next_rd_ff == Sentinel);
      status.evict_due   = !hit_ff &&
                           (lkvc_pkg::CAP_WIDTH'(count_ff) > capacity);
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= LinkWidth'(TableDepth))
      else $error("Entry count exceeds the table depth.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.evicted) |-> !rsp_data_ff.hit)
      else $error("Eviction reported on a hit.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.evicted) |-> (rsp_data_ff.evicted_key == '0))
      else $error("Evicted key is nonzero without an eviction.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> (head_ff != Sentinel))
      else $error("Eviction from an empty recency list.");

endmodule
